### design/rpa_pkg.sv
package rpa_pkg;

	localparam int MAX_PAGES  = 65536;
	localparam int PAGE_SHIFT = 12;
	localparam int WORD_W     = 64;
	localparam int BIT_W      = $clog2(WORD_W);
	localparam int NWORDS     = MAX_PAGES / WORD_W;
	localparam int WD_W       = $clog2(NWORDS);
	localparam int PG_W       = $clog2(MAX_PAGES);
	localparam int CNT_W      = PG_W + 1;
	localparam int TOT_W      = 17;
	localparam int BADDR_W    = 32;
	localparam int INPG_W     = BADDR_W - PAGE_SHIFT;
	localparam int ADDR_W     = 28;
	localparam int RC_W       = 16;
	localparam logic [RC_W-1:0] COUNT_MAX = 16'hffff;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RETAIN  = 2'd1,
		OP_FREE    = 2'd2,
		OP_RESERVE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	function automatic logic [BIT_W-1:0] find_low(input logic [WORD_W-1:0] v);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (v[i]) r = BIT_W'(i);
		end
		return r;
	endfunction

endpackage

### design/rpa_ram.sv
module rpa_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

### design/refcounted_page_allocator.sv
// Page frame allocator with a 16-bit reference count per page. The used map
// lives in a RAM of 64-bit words and the counts in a RAM of one entry per
// page. After reset the block runs a clearing pass over the used map, one word
// a cycle, with busy high; configuration writes are still taken. A request is
// taken when start is high and busy is low; busy then stays high until the
// result beat. Retain, free and reserve finish in their one exec state, and
// done is registered from it. Alloc scans the used map one word per cycle from
// word 0 and ends at the word holding the lowest free page (or at the last
// word below total_pages when none is free). The result appears on the result
// ports in the cycle in which done is high and holds until the next result;
// the receiver cannot stall it, so capture it then.
module refcounted_page_allocator
	import rpa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [TOT_W-1:0]   cfg_wdata,
	input  logic               start,
	input  logic [1:0]         func,
	input  logic [BADDR_W-1:0] byte_addr,
	output logic               busy,
	output logic               done,
	output logic [ADDR_W-1:0]  page_addr,
	output logic               status,
	output logic [CNT_W-1:0]   used_count,
	output logic [CNT_W-1:0]   free_count
);

	state_t state_q, state_d;

	logic [TOT_W-1:0] total_q;
	logic [CNT_W-1:0] used_q;
	logic [WD_W-1:0]  clr_q;
	logic [WD_W-1:0]  w_q;
	logic [PG_W-1:0]  page_q;
	logic             inrange_q;
	op_t              op_q;

	// effective total: clamp to the managed page count
	logic [CNT_W-1:0] eff;
	assign eff = (total_q > TOT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : CNT_W'(total_q);

	// incoming page number
	logic [INPG_W-1:0] in_pg;
	assign in_pg = byte_addr[BADDR_W-1:PAGE_SHIFT];

	logic accept;
	assign accept = (state_q == ST_IDLE) && start;

	// RAM ports
	logic              bm_we, cnt_we;
	logic [WD_W-1:0]   bm_waddr, bm_raddr;
	logic [WORD_W-1:0] bm_wdata, bm_rdata;
	logic [PG_W-1:0]   cnt_waddr;
	logic [RC_W-1:0]   cnt_wdata, cnt_rdata;

	rpa_ram #(.W(WORD_W), .D(NWORDS)) u_map (
		.clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
		.raddr(bm_raddr), .rdata(bm_rdata)
	);

	rpa_ram #(.W(RC_W), .D(MAX_PAGES)) u_cnt (
		.clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.raddr(PG_W'(in_pg)), .rdata(cnt_rdata)
	);

	// alloc scan of the current word
	logic [CNT_W-BIT_W-1:0] tw;
	logic [BIT_W-1:0]       tb;
	logic [WORD_W-1:0]      vmask, avail;
	logic                   found, last;
	logic [BIT_W-1:0]       idx;
	logic [WD_W:0]          w_nx;

	assign tw = eff[CNT_W-1:BIT_W];
	assign tb = eff[BIT_W-1:0];
	assign w_nx = {1'b0, w_q} + 1'b1;

	always_comb begin
		if ((CNT_W-BIT_W)'(w_q) < tw) vmask = '1;
		else if ((CNT_W-BIT_W)'(w_q) == tw) vmask = (WORD_W'(1) << tb) - WORD_W'(1);
		else vmask = '0;
		// page 0 is never handed out
		if (w_q == '0) vmask[0] = 1'b0;
	end

	assign avail = ~bm_rdata & vmask;
	assign found = |avail;
	assign idx   = find_low(avail);
	assign last  = {w_nx, {BIT_W{1'b0}}} >= (WD_W+1+BIT_W)'(eff);

	// single-page operations
	logic            bit_cur, managed;
	logic [BIT_W-1:0] bsel;
	assign bsel    = page_q[BIT_W-1:0];
	assign bit_cur = bm_rdata[bsel];
	assign managed = inrange_q && (page_q != '0) && (CNT_W'(page_q) < eff) && bit_cur;

	logic             res_status, res_done;
	logic [PG_W-1:0]  res_page;
	logic [CNT_W-1:0] used_nx;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == WD_W'(NWORDS - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (start) state_d = ST_EXEC;
			ST_EXEC:  if (res_done) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// RAM control and result
	always_comb begin
		bm_we      = 1'b0;
		bm_waddr   = w_q;
		bm_wdata   = bm_rdata;
		bm_raddr   = w_q;
		cnt_we     = 1'b0;
		cnt_waddr  = page_q;
		cnt_wdata  = cnt_rdata;
		res_status = 1'b1;
		res_done   = 1'b0;
		res_page   = '0;
		used_nx    = used_q;
		unique case (state_q)
			ST_CLEAR: begin
				bm_we    = 1'b1;
				bm_waddr = clr_q;
				bm_wdata = '0;
			end
			ST_IDLE: begin
				bm_raddr = (func == OP_ALLOC) ? '0 : WD_W'(in_pg >> BIT_W);
			end
			ST_EXEC: begin
				bm_raddr = w_nx[WD_W-1:0];
				case (op_q)
					OP_ALLOC: begin
						if (found) begin
							res_done   = 1'b1;
							res_status = 1'b0;
							res_page   = {w_q, idx};
							bm_we      = 1'b1;
							bm_wdata   = bm_rdata | (WORD_W'(1) << idx);
							cnt_we     = 1'b1;
							cnt_waddr  = {w_q, idx};
							cnt_wdata  = RC_W'(1);
							used_nx    = used_q + 1'b1;
						end else if (last) begin
							res_done = 1'b1;
						end
					end
					OP_RETAIN: begin
						res_done = 1'b1;
						if (managed) begin
							res_status = 1'b0;
							cnt_we     = 1'b1;
							if (cnt_rdata != COUNT_MAX) cnt_wdata = cnt_rdata + 1'b1;
						end
					end
					OP_FREE: begin
						res_done = 1'b1;
						if (managed) begin
							res_status = 1'b0;
							cnt_we     = 1'b1;
							if (cnt_rdata > RC_W'(1)) begin
								cnt_wdata = cnt_rdata - 1'b1;
							end else begin
								cnt_wdata      = '0;
								bm_we          = 1'b1;
								bm_wdata[bsel] = 1'b0;
								if (used_q != '0) used_nx = used_q - 1'b1;
							end
						end
					end
					default: begin
						res_done = 1'b1;
						if (inrange_q && !bit_cur) begin
							res_status     = 1'b0;
							bm_we          = 1'b1;
							bm_wdata[bsel] = 1'b1;
							cnt_we         = 1'b1;
							cnt_wdata      = '0;
							used_nx        = used_q + 1'b1;
						end
					end
				endcase
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			total_q <= TOT_W'(65536);
			used_q  <= '0;
			clr_q   <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) total_q <= cfg_wdata;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			used_q <= used_nx;
			done   <= res_done;
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= op_t'(func);
			page_q    <= PG_W'(in_pg);
			inrange_q <= (in_pg >> PG_W) == '0;
			w_q       <= (func == OP_ALLOC) ? '0 : WD_W'(in_pg >> BIT_W);
		end else if (state_q == ST_EXEC && !res_done) begin
			// advance the scan to the next word
			w_q <= w_nx[WD_W-1:0];
		end
		if (res_done) begin
			page_addr  <= ADDR_W'({res_page, {PAGE_SHIFT{1'b0}}});
			status     <= res_status;
			used_count <= used_nx;
			free_count <= (eff > used_nx) ? eff - used_nx : '0;
		end
	end

	assign busy = (state_q != ST_IDLE);

`ifndef NO_ASSERTIONS
	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_EXEC)) else $error("done without exec");
	a_addr_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && page_addr != '0) |-> !status) else $error("addr with fail");
	a_used_max: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(MAX_PAGES)) else $error("used count overflow");
	a_busy_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy) else $error("not busy after accept");
`endif

endmodule
